/* hdl/sekg_pkg.sv */
// Shared types, datapath commands and exponential tables for the kernel gradient block.
`timescale 1ns / 1ps
package sekg_pkg;

  localparam int unsigned ExpSteps = 13;
  localparam int unsigned AddrWidth = 3;

  // Register byte addresses on the configuration port.
  localparam logic [AddrWidth-1:0] AddrSigma   = 3'd0;
  localparam logic [AddrWidth-1:0] AddrInvLen  = 3'd4;

  typedef struct packed {
    logic signed [15:0] component_a;
    logic signed [15:0] component_b;
    logic [15:0]        cutoff_a;
    logic [15:0]        cutoff_b;
    logic               last_component;
  } in_item_t;

  typedef struct packed {
    logic [31:0] kernel_value;
    logic [31:0] sigma_gradient;
    logic [31:0] length_gradient;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_P1, OP_P2, OP_EXP, OP_LIN, OP_VAL, OP_KERN, OP_SGRAD,
    OP_LG1, OP_LG2, OP_LOAD
  } op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t        op;
    logic [3:0] step;
  } cmd_t;

  // Q0.32 values of exp(-w) for w = 1, 2, 4, 8, 16, then 1/2 down to 1/256.
  function automatic logic [31:0] exp_factor(input logic [3:0] step);
    logic [31:0] t;
    case (step)
      4'd0:    t = 32'd1580030169;
      4'd1:    t = 32'd581260615;
      4'd2:    t = 32'd78665070;
      4'd3:    t = 32'd1440801;
      4'd4:    t = 32'd483;
      4'd5:    t = 32'd2605029348;
      4'd6:    t = 32'd3344923894;
      4'd7:    t = 32'd3790295335;
      4'd8:    t = 32'd4034748382;
      4'd9:    t = 32'd4162825045;
      4'd10:   t = 32'd4228380000;
      4'd11:   t = 32'd4261543595;
      4'd12:   t = 32'd4278203082;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

/* hdl/squared_exponential_kernel_grad.sv */
// Top level: squared-exponential kernel entry with sigma and length-scale gradients.
`timescale 1ns / 1ps
// Component pairs stream in at one transaction per cycle; each one adds its squared
// difference to a saturating 48-bit accumulator. The transaction flagged last also
// starts a tail sequence that runs through one shared step counter and a chain of
// registered multiplies: the exponent argument, the table exponential and its linear
// correction, then the cutoff, kernel and gradient products and the output load. The
// input stalls during the tail, and the output load also waits until any earlier
// result has left the output register; a finished result waits there while the next
// pair streams in.
// Configuration: signal_sigma at address 0, inverse_length at 4.
module squared_exponential_kernel_grad (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sekg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sekg_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sekg_pkg::*;

  logic [15:0] signal_sigma;
  logic [15:0] inverse_length;
  logic        in_accept;
  cmd_t        cmd;

  assign pready    = 1'b1;
  assign in_accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      signal_sigma   <= 16'd256;
      inverse_length <= 16'd256;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrSigma) begin
        signal_sigma <= pwdata[15:0];
      end else if (paddr == AddrInvLen) begin
        inverse_length <= pwdata[15:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr)
      AddrSigma:  prdata = {16'd0, signal_sigma};
      AddrInvLen: prdata = {16'd0, inverse_length};
      default:    prdata = '0;
    endcase
  end

  sekg_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .last_component (in_data.last_component),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd)
  );

  sekg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_accept      (in_accept),
    .in_data        (in_data),
    .cmd            (cmd),
    .signal_sigma   (signal_sigma),
    .inverse_length (inverse_length),
    .out_data       (out_data)
  );

endmodule

/* hdl/sekg_ctrl.sv */
// Controller that sequences the per-pair tail computation and the output register.
`timescale 1ns / 1ps
module sekg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_component,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sekg_pkg::cmd_t cmd
);
  import sekg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_EXP, S_LIN, S_VAL, S_KERN, S_SGRAD, S_LG1, S_LG2, S_DONE
  } state_t;

  state_t     state;
  logic [3:0] step;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Command decode from the current state.
  always_comb begin
    cmd.step = step;
    case (state)
      S_P1:    cmd.op = OP_P1;
      S_P2:    cmd.op = OP_P2;
      S_EXP:   cmd.op = OP_EXP;
      S_LIN:   cmd.op = OP_LIN;
      S_VAL:   cmd.op = OP_VAL;
      S_KERN:  cmd.op = OP_KERN;
      S_SGRAD: cmd.op = OP_SGRAD;
      S_LG1:   cmd.op = OP_LG1;
      S_LG2:   cmd.op = OP_LG2;
      S_DONE:  cmd.op = out_free ? OP_LOAD : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && last_component) begin
            state <= S_P1;
          end
        end
        S_P1: state <= S_P2;
        S_P2: begin
          state <= S_EXP;
          step  <= '0;
        end
        S_EXP: begin
          if (step == 4'(ExpSteps - 1)) begin
            state <= S_LIN;
          end
          step <= step + 4'd1;
        end
        S_LIN:   state <= S_VAL;
        S_VAL:   state <= S_KERN;
        S_KERN:  state <= S_SGRAD;
        S_SGRAD: state <= S_LG1;
        S_LG1:   state <= S_LG2;
        S_LG2:   state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/sekg_dp.sv */
// Datapath: distance accumulation, exponent argument, table exponential and outputs.
`timescale 1ns / 1ps
module sekg_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  sekg_pkg::in_item_t  in_data,
  input  sekg_pkg::cmd_t      cmd,
  input  logic [15:0]         signal_sigma,
  input  logic [15:0]         inverse_length,
  output sekg_pkg::out_item_t out_data
);
  import sekg_pkg::*;

  logic [47:0] acc;
  logic [31:0] cut;
  logic [63:0] p1;
  logic [31:0] sig2;
  logic [20:0] arg;
  logic [32:0] e;
  logic [31:0] val;
  logic [31:0] kern;
  logic [31:0] sgrad;
  logic [36:0] lg_mid;

  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [48:0]        acc_sum;
  logic [79:0]        p2;
  logic [4:0]         bit_pos;
  logic [64:0]        e_prod;
  logic [49:0]        lin_prod;
  logic [52:0]        lg_prod;

  // Squared component difference added to the saturating accumulator.
  assign diff    = 17'(in_data.component_a) - 17'(in_data.component_b);
  assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
  assign acc_sum = {1'b0, acc} + (49'(mag) * 49'(mag));

  assign p2      = p1 * 80'(inverse_length);
  assign bit_pos = (cmd.step < 4'd5) ? 5'(cmd.step) + 5'd16 : 5'd20 - 5'(cmd.step);
  assign e_prod  = 65'(e) * 65'(exp_factor(cmd.step));
  assign lin_prod = 50'(e) * 50'(17'h10000 - {9'd0, arg[7:0]});
  assign lg_prod = 53'(lg_mid) * 53'(inverse_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      if (in_accept) begin
        acc <= acc_sum[48] ? '1 : acc_sum[47:0];
      end else if (cmd.op == OP_P1) begin
        acc <= '0;
      end
    end
  end

  // Tail steps registering their multiply results, the output load, and the cutoff product.
  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_component) begin
      cut <= in_data.cutoff_a * in_data.cutoff_b;
    end
    case (cmd.op)
      OP_P1: begin
        p1   <= 64'(acc) * 64'(inverse_length);
        sig2 <= signal_sigma * signal_sigma;
      end
      OP_P2: begin
        arg <= p2[45:25];
        e   <= (|p2[79:46]) ? 33'd0 : 33'h1_0000_0000;
      end
      OP_EXP: begin
        if (arg[bit_pos]) begin
          e <= e_prod[64:32];
        end
      end
      OP_LIN:   e <= lin_prod[48:16];
      OP_VAL:   val <= 32'((65'(e) * 65'(cut)) >> 32);
      OP_KERN:  kern <= 32'((64'(sig2) * 64'(val)) >> 32);
      OP_SGRAD: sgrad <= 32'((48'(signal_sigma) * 48'(val)) >> 23);
      OP_LG1:   lg_mid <= 37'((53'(kern) * 53'(arg)) >> 16);
      OP_LG2:   lg_mid <= (|lg_prod[52:39]) ? '1 : 37'(lg_prod[38:7]);
      OP_LOAD: begin
        out_data.kernel_value    <= kern;
        out_data.sigma_gradient  <= sgrad;
        out_data.length_gradient <= lg_mid[31:0];
      end
      default: ;
    endcase
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the squared-exponential kernel gradient block.
`timescale 1ns / 1ps
module tb_top;
  import sekg_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and configuration shadow.
  logic [47:0] dist_acc;
  logic [15:0] sigma_q;
  logic [15:0] inv_len_q;
  bit          failed;

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int          burst_left;
  int          gap_left;
  int          stall_phase;

  squared_exponential_kernel_grad u_top (.*);

  always #1 clk = ~clk;

  // Appends one input transaction to the pending queue.
  task automatic enqueue_item(input in_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Table-driven exp(-x) with x in Q.16, result in Q0.32.
  function automatic logic [63:0] neg_exp(input logic [63:0] x);
    logic [63:0] e;
    logic [31:0] tab[13];
    tab = '{32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801, 32'd483,
            32'd2605029348, 32'd3344923894, 32'd3790295335, 32'd4034748382,
            32'd4162825045, 32'd4228380000, 32'd4261543595, 32'd4278203082};
    e = 64'd1 << 32;
    if (x >= (64'd32 << 16)) return 64'd0;
    for (int i = 0; i < 5; i++)
      if (x[16+i]) e = (e * tab[i]) >> 32;
    for (int i = 0; i < 8; i++)
      if (x[15-i]) e = (e * tab[5+i]) >> 32;
    e = (e * (64'd65536 - x[7:0])) >> 16;
    return e;
  endfunction

  // Accumulates one component pair and, on the last one, predicts the result.
  task automatic predict_kernel(input in_item_t it);
    logic signed [17:0] d;
    logic [63:0] sq, sum, inv2, hi, lo, arg, e, cut, val, kern, sgrad, lgrad;
    out_item_t r;
    d = 18'(it.component_a) - 18'(it.component_b);
    sq = (d < 0) ? 64'(-d) : 64'(d);
    sq = sq * sq;
    sum = 64'(dist_acc) + sq;
    dist_acc = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
    if (!it.last_component) return;
    inv2 = 64'(inv_len_q) * 64'(inv_len_q);
    hi = 64'(dist_acc >> 24) * inv2;
    lo = 64'(dist_acc[23:0]) * inv2;
    arg = (hi >> 1) + ((lo + ((hi & 64'd1) << 24)) >> 25);
    e = neg_exp(arg);
    cut = 64'(it.cutoff_a) * 64'(it.cutoff_b);
    val = (e * cut) >> 32;
    kern = ((64'(sigma_q) * 64'(sigma_q)) * val) >> 32;
    sgrad = (64'(sigma_q) * val) >> 23;
    if (arg >= (64'd32 << 16)) lgrad = 0;
    else lgrad = (((kern * arg) >> 16) * 64'(inv_len_q)) >> 7;
    r.kernel_value = (kern > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : kern[31:0];
    r.sigma_gradient = (sgrad > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sgrad[31:0];
    r.length_gradient = (lgrad > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lgrad[31:0];
    expected_results = {expected_results, r};
    dist_acc = '0;
  endtask

  // Driver: bursty sender fed from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic bit done = in_valid && in_ready;
      if (done) predict_kernel(in_data);
      if (!in_valid || done) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stall pattern and result check.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[9:8] == 2'd3) ? 1'b1 :
                   ((stall_phase % 7) != 3) && ($urandom_range(0, 4) != 0);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          failed = 1'b1;
        end else begin
          automatic out_item_t x = expected_results.pop_front();
          if (out_data.kernel_value !== x.kernel_value) begin
            $error("kernel_value: expected %0d, got %0d", x.kernel_value,
                   out_data.kernel_value);
            failed = 1'b1;
          end
          if (out_data.sigma_gradient !== x.sigma_gradient) begin
            $error("sigma_gradient: expected %0d, got %0d", x.sigma_gradient,
                   out_data.sigma_gradient);
            failed = 1'b1;
          end
          if (out_data.length_gradient !== x.length_gradient) begin
            $error("length_gradient: expected %0d, got %0d", x.length_gradient,
                   out_data.length_gradient);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Register write over the configuration port.
  task automatic reg_write(input logic [2:0] addr, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'(~value), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrSigma) sigma_q = value;
    else inv_len_q = value;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t make_item(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] ca, input logic [15:0] cb,
                                         input logic lst);
    in_item_t it;
    it.component_a = a;
    it.component_b = b;
    it.cutoff_a = ca;
    it.cutoff_b = cb;
    it.last_component = lst;
    return it;
  endfunction

  // Random vector pairs; mostly small differences so the exponential stays live.
  task automatic queue_random_pairs(input int n_items);
    int cnt;
    int len;
    int spread;
    cnt = 0;
    while (cnt < n_items) begin
      len = $urandom_range(1, 8);
      spread = $urandom_range(0, 9);
      for (int k = 0; k < len; k++) begin
        logic [15:0] a, b;
        a = $urandom;
        if (spread == 0) b = $urandom;
        else if (spread < 4) b = a + 16'($urandom_range(0, 2047)) - 16'd1024;
        else b = a + 16'($urandom_range(0, 255)) - 16'd128;
        enqueue_item(make_item(a, b, $urandom, $urandom, k == len - 1));
        cnt++;
      end
    end
  endtask

  // Stimulus sequence with configuration phases.
  initial begin
    logic [15:0] sig_set[5];
    logic [15:0] inv_set[5];
    sig_set = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'd700};
    inv_set = '{16'd256, 16'd1, 16'hFFFF, 16'd16, 16'd2000};
    dist_acc = '0;
    sigma_q = 16'd256;
    inv_len_q = 16'd256;
    failed = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identical vectors, extremes, saturation, single-component pairs.
    enqueue_item(make_item(16'h1000, 16'h1000, 16'hFFFF, 16'hFFFF, 1'b1));
    enqueue_item(make_item(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
    enqueue_item(make_item(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1));
    for (int k = 0; k < 6; k++)
      enqueue_item(make_item(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, k == 5));
    enqueue_item(make_item(16'h0100, 16'h0000, 16'h8000, 16'hFFFF, 1'b0));
    enqueue_item(make_item(16'h0000, 16'h0080, 16'hFFFF, 16'h8000, 1'b1));
    enqueue_item(make_item(16'h0010, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
    enqueue_item(make_item(16'h8000, 16'h8000, 16'hAAAA, 16'h5555, 1'b1));
    wait_drained();

    // Random phases across register settings, extremes included.
    for (int p = 0; p < 5; p++) begin
      reg_write(AddrSigma, sig_set[p]);
      reg_write(AddrInvLen, inv_set[p]);
      enqueue_item(make_item(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1));
      enqueue_item(make_item(16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
      queue_random_pairs(120);
      wait_drained();
    end
    // Zero length-scale reciprocal is allowed by the register width.
    reg_write(AddrInvLen, 16'd0);
    queue_random_pairs(20);
    wait_drained();

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
